// ===== hw/rtl/qnm_pkg.sv =====
package qnm_pkg;

  localparam int FRAC_BITS = 14;
  localparam int NSTG      = FRAC_BITS + 1;
  localparam int SW        = 33;
  localparam int QW        = 31;
  localparam int RW        = 2 * FRAC_BITS + 2 + QW;
  localparam int AW        = 2 * FRAC_BITS + 37;
  localparam int BW        = FRAC_BITS + 36;
  localparam int EW        = ((2 * FRAC_BITS + 2) > 34 ? 2 * FRAC_BITS + 2 : 34) + 2;
  localparam int OW        = 18;

  typedef enum logic [0:0] {
    OP_NORM = 1'b0,
    OP_MAT  = 1'b1
  } op_t;

endpackage

// ===== hw/rtl/quaternion_normalize_and_matrix_core.sv =====
// Throughput: one request per cycle while the output is not stalled; the normalize
//   root search is a pipeline of FRAC_BITS + 1 add-and-compare stages per component,
//   one result bit each.
// A stall at the output holds every stage; no request is lost or repeated.
// Reset (rst_n low, synchronous) clears all valid bits; data registers keep values.
module quaternion_normalize_and_matrix_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // qx, qy, qz, qw
  input  logic [0:0]   in_tuser,   // opcode
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [167:0] out_tdata,  // r0, r1, r2, r3, r4, r5, r6, r7, r8, zero pad
  output logic [0:0]   out_tuser   // zero_norm
);

  localparam int F = qnm_pkg::FRAC_BITS;
  localparam int L = qnm_pkg::NSTG;
  localparam int EW = qnm_pkg::EW;

  function automatic logic [17:0] round_sat(input logic signed [EW-1:0] e);
    logic          neg;
    logic [EW-1:0] mag;
    logic [EW-1:0] rr;
    neg = e[EW-1];
    mag = neg ? EW'(-e) : EW'(e);
    rr  = (mag + (EW'(1) << (F - 1))) >> F;
    if (neg) begin
      round_sat = (rr > EW'(131072)) ? 18'h20000 : 18'(-rr);
    end else begin
      round_sat = (rr > EW'(131071)) ? 18'h1FFFF : rr[17:0];
    end
  endfunction

  logic en;
  logic signed [15:0] q [4];

  logic               v1_r;
  qnm_pkg::op_t       op1_r;
  logic signed [31:0] p1_r [10];

  logic               v2_r;
  qnm_pkg::op_t       op2_r;
  logic [qnm_pkg::SW-1:0] s2_r;
  logic [qnm_pkg::QW-1:0] sq2_r [4];
  logic [3:0]         neg1_r, neg2_r;
  logic signed [EW-1:0] e2_r [9];

  logic               v_r   [L];
  qnm_pkg::op_t       op_r  [L];
  logic               z_r   [L];
  logic [3:0]         neg_r [L];
  logic [17:0]        mres_r [L][9];

  logic [F:0]         m_w [4];

  logic               out_tvalid_r;
  logic [17:0]        res_r [9];
  logic               zero_r;

  assign en = !out_tvalid_r || out_tready;
  assign in_tready = en;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      q[i] = $signed(in_tdata[16*i +: 16]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      for (int k = 0; k < L; k++) begin
        v_r[k] <= 1'b0;
      end
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v_r[0] <= v2_r;
      for (int k = 1; k < L; k++) begin
        v_r[k] <= v_r[k-1];
      end
      out_tvalid_r <= v_r[L-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r   <= qnm_pkg::op_t'(in_tuser[0]);
      p1_r[0] <= q[0] * q[0];
      p1_r[1] <= q[1] * q[1];
      p1_r[2] <= q[2] * q[2];
      p1_r[3] <= q[3] * q[3];
      p1_r[4] <= q[0] * q[1];
      p1_r[5] <= q[0] * q[2];
      p1_r[6] <= q[1] * q[2];
      p1_r[7] <= q[0] * q[3];
      p1_r[8] <= q[1] * q[3];
      p1_r[9] <= q[2] * q[3];
      for (int i = 0; i < 4; i++) begin
        neg1_r[i] <= q[i][15];
      end

      op2_r  <= op1_r;
      neg2_r <= neg1_r;
      s2_r   <= qnm_pkg::SW'(p1_r[0][30:0]) + qnm_pkg::SW'(p1_r[1][30:0])
              + qnm_pkg::SW'(p1_r[2][30:0]) + qnm_pkg::SW'(p1_r[3][30:0]);
      for (int i = 0; i < 4; i++) begin
        sq2_r[i] <= p1_r[i][30:0];
      end
      e2_r[0] <= (EW'(1) <<< (2*F)) - (EW'(p1_r[1]) <<< 1) - (EW'(p1_r[2]) <<< 1);
      e2_r[1] <= (EW'(p1_r[4]) <<< 1) - (EW'(p1_r[9]) <<< 1);
      e2_r[2] <= (EW'(p1_r[5]) <<< 1) + (EW'(p1_r[8]) <<< 1);
      e2_r[3] <= (EW'(p1_r[4]) <<< 1) + (EW'(p1_r[9]) <<< 1);
      e2_r[4] <= (EW'(1) <<< (2*F)) - (EW'(p1_r[0]) <<< 1) - (EW'(p1_r[2]) <<< 1);
      e2_r[5] <= (EW'(p1_r[6]) <<< 1) - (EW'(p1_r[7]) <<< 1);
      e2_r[6] <= (EW'(p1_r[5]) <<< 1) - (EW'(p1_r[8]) <<< 1);
      e2_r[7] <= (EW'(p1_r[6]) <<< 1) + (EW'(p1_r[7]) <<< 1);
      e2_r[8] <= (EW'(1) <<< (2*F)) - (EW'(p1_r[0]) <<< 1) - (EW'(p1_r[1]) <<< 1);

      op_r[0]  <= op2_r;
      z_r[0]   <= (op2_r == qnm_pkg::OP_NORM) && (s2_r == '0);
      neg_r[0] <= neg2_r;
      for (int i = 0; i < 9; i++) begin
        mres_r[0][i] <= round_sat(e2_r[i]);
      end
      for (int k = 1; k < L; k++) begin
        op_r[k]  <= op_r[k-1];
        z_r[k]   <= z_r[k-1];
        neg_r[k] <= neg_r[k-1];
        for (int i = 0; i < 9; i++) begin
          mres_r[k][i] <= mres_r[k-1][i];
        end
      end
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_lane
    qnm_norm_lane u_lane (
      .clk  (clk),
      .en   (en),
      .s_i  (s2_r),
      .sq_i (sq2_r[i]),
      .m_o  (m_w[i])
    );
  end

  always_ff @(posedge clk) begin
    logic [31:0] mc;
    if (en) begin
      zero_r <= z_r[L-1];
      if (z_r[L-1]) begin
        for (int i = 0; i < 9; i++) begin
          res_r[i] <= '0;
        end
      end else if (op_r[L-1] == qnm_pkg::OP_MAT) begin
        for (int i = 0; i < 9; i++) begin
          res_r[i] <= mres_r[L-1][i];
        end
      end else begin
        for (int i = 0; i < 4; i++) begin
          mc = 32'(m_w[i]);
          if (mc > 32'd131071) begin
            mc = 32'd131071;
          end
          res_r[i] <= neg_r[L-1][i] ? 18'(-mc[17:0]) : mc[17:0];
        end
        for (int i = 4; i < 9; i++) begin
          res_r[i] <= '0;
        end
      end
    end
  end

  always_comb begin
    out_tdata = '0;
    for (int i = 0; i < 9; i++) begin
      out_tdata[18*i +: 18] = res_r[i];
    end
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_tuser[0] = zero_r;

  a_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("zero norm result carries nonzero data");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |=> $stable(v_r[L-1]) && $stable(zero_r))
    else $error("pipeline advanced during stall");

endmodule

// ===== hw/rtl/qnm_norm_lane.sv =====
module qnm_norm_lane (
  input  logic                             clk,
  input  logic                             en,
  input  logic [qnm_pkg::SW-1:0]           s_i,
  input  logic [qnm_pkg::QW-1:0]           sq_i,
  output logic [qnm_pkg::FRAC_BITS:0]      m_o
);

  logic [qnm_pkg::AW-1:0]        a_r [qnm_pkg::NSTG];
  logic signed [qnm_pkg::BW-1:0] b_r [qnm_pkg::NSTG];
  logic [qnm_pkg::RW-1:0]        r_r [qnm_pkg::NSTG];
  logic [qnm_pkg::SW-1:0]        s_r [qnm_pkg::NSTG];
  logic [qnm_pkg::FRAC_BITS:0]   m_r [qnm_pkg::NSTG];

  for (genvar j = 0; j < qnm_pkg::NSTG; j++) begin : g_stg
    localparam int K = qnm_pkg::FRAC_BITS - j;
    logic [qnm_pkg::AW-1:0]        a_p;
    logic signed [qnm_pkg::BW-1:0] b_p;
    logic [qnm_pkg::RW-1:0]        r_p;
    logic [qnm_pkg::SW-1:0]        s_p;
    logic [qnm_pkg::FRAC_BITS:0]   m_p;
    logic signed [qnm_pkg::AW+1:0] t;
    logic                          take;

    if (j == 0) begin : g_first
      assign a_p = qnm_pkg::AW'(s_i);
      assign b_p = -$signed(qnm_pkg::BW'(s_i));
      assign r_p = qnm_pkg::RW'(sq_i) << (2 * qnm_pkg::FRAC_BITS + 2);
      assign s_p = s_i;
      assign m_p = '0;
    end else begin : g_next
      assign a_p = a_r[j-1];
      assign b_p = b_r[j-1];
      assign r_p = r_r[j-1];
      assign s_p = s_r[j-1];
      assign m_p = m_r[j-1];
    end

    assign t = $signed({2'b00, a_p})
             + ((qnm_pkg::AW+2)'(b_p) <<< (K + 2))
             + $signed((qnm_pkg::AW+2)'(s_p) << (2 * K + 2));
    assign take = t <= $signed((qnm_pkg::AW+2)'(r_p));

    always_ff @(posedge clk) begin
      if (en) begin
        s_r[j] <= s_p;
        r_r[j] <= r_p;
        if (take) begin
          a_r[j] <= qnm_pkg::AW'(t);
          b_r[j] <= b_p + $signed(qnm_pkg::BW'(s_p) << (K + 1));
          m_r[j] <= m_p | ((qnm_pkg::FRAC_BITS+1)'(1) << K);
        end else begin
          a_r[j] <= a_p;
          b_r[j] <= b_p;
          m_r[j] <= m_p;
        end
      end
    end
  end

  assign m_o = m_r[qnm_pkg::NSTG-1];

endmodule

// ===== verif/quaternion_normalize_and_matrix_core_tb.sv =====
`timescale 1ns / 100ps

module quaternion_normalize_and_matrix_core_tb;

  typedef struct packed {
    logic [8:0][17:0] entry;
    logic             zero_norm;
  } rotation_result_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [63:0]  in_tdata;
  logic [0:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [167:0] out_tdata;
  logic [0:0]   out_tuser;

  rotation_result_t pending_results[$];
  int               mismatch_count;
  int               burst_left;
  int               hold_cycles;
  int               stall_mode;
  bit               stimulus_done;

  quaternion_normalize_and_matrix_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [17:0] clamp18(longint v);
    if (v > 131071) v = 131071;
    if (v < -131072) v = -131072;
    return v[17:0];
  endfunction

  function automatic longint unit_magnitude(longint aq, longint sum_sq);
    logic [127:0] rhs;
    logic [127:0] lhs;
    logic [127:0] odd;
    longint       lo;
    longint       hi;
    longint       mid;
    rhs = (128'(4 * aq * aq)) << (2 * qnm_pkg::FRAC_BITS);
    lo  = 0;
    hi  = 131072;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      odd = 128'(2 * mid - 1);
      lhs = odd * odd * 128'(sum_sq);
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic longint round_to_frac(longint v);
    longint half;
    half = longint'(1) << (qnm_pkg::FRAC_BITS - 1);
    if (v >= 0) return (v + half) >>> qnm_pkg::FRAC_BITS;
    return -((-v + half) >>> qnm_pkg::FRAC_BITS);
  endfunction

  function automatic rotation_result_t predict_rotation(qnm_pkg::op_t op,
                                                        logic [63:0] q_bits);
    rotation_result_t r;
    longint           q[4];
    longint           sum_sq;
    longint           one;
    longint           e[9];
    longint           m;
    longint           x;
    longint           y;
    longint           z;
    longint           w;
    r = '0;
    for (int i = 0; i < 4; i++) q[i] = longint'($signed(q_bits[16*i +: 16]));
    if (op == qnm_pkg::OP_NORM) begin
      sum_sq = 0;
      for (int i = 0; i < 4; i++) sum_sq += q[i] * q[i];
      if (sum_sq == 0) begin
        r.zero_norm = 1'b1;
      end else begin
        for (int i = 0; i < 4; i++) begin
          m = unit_magnitude(q[i] < 0 ? -q[i] : q[i], sum_sq);
          r.entry[i] = clamp18(q[i] < 0 ? -m : m);
        end
      end
    end else begin
      x = q[0]; y = q[1]; z = q[2]; w = q[3];
      one = longint'(1) << (2 * qnm_pkg::FRAC_BITS);
      e[0] = one - 2*y*y - 2*z*z;
      e[1] = 2*x*y - 2*z*w;
      e[2] = 2*x*z + 2*y*w;
      e[3] = 2*x*y + 2*z*w;
      e[4] = one - 2*x*x - 2*z*z;
      e[5] = 2*y*z - 2*x*w;
      e[6] = 2*x*z - 2*y*w;
      e[7] = 2*y*z + 2*x*w;
      e[8] = one - 2*x*x - 2*y*y;
      for (int i = 0; i < 9; i++) r.entry[i] = clamp18(round_to_frac(e[i]));
    end
    return r;
  endfunction

  task automatic send_request(qnm_pkg::op_t op, logic [15:0] qx, logic [15:0] qy,
                              logic [15:0] qz, logic [15:0] qw, bit no_gap = 0);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {qw, qz, qy, qx};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_rotation(op, {qw, qz, qy, qx}));
    if (no_gap) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic idle_sender();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    idle_sender();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_normalize_directed();
    send_request(qnm_pkg::OP_NORM, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_request(qnm_pkg::OP_NORM, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_request(qnm_pkg::OP_NORM, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_request(qnm_pkg::OP_NORM, 16'h8000, 16'h0000, 16'h0000, 16'h0000);
    send_request(qnm_pkg::OP_NORM, 16'h0000, 16'h0000, 16'h0000, 16'h7fff);
    send_request(qnm_pkg::OP_NORM, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
    send_request(qnm_pkg::OP_NORM, 16'h0000, 16'hffff, 16'h0000, 16'h0001);
    send_request(qnm_pkg::OP_NORM, 16'h7fff, 16'h8000, 16'h0001, 16'hffff);
    send_request(qnm_pkg::OP_NORM, 16'h0000, 16'h0000, 16'h4000, 16'h0000);
    send_request(qnm_pkg::OP_NORM, 16'h2000, 16'h2000, 16'h2000, 16'h2000);
    wait_drained();
  endtask

  task automatic test_matrix_directed();
    send_request(qnm_pkg::OP_MAT, 16'h0000, 16'h0000, 16'h0000, 16'h4000);
    send_request(qnm_pkg::OP_MAT, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_request(qnm_pkg::OP_MAT, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_request(qnm_pkg::OP_MAT, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_request(qnm_pkg::OP_MAT, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_request(qnm_pkg::OP_MAT, 16'h2d41, 16'h0000, 16'h0000, 16'h2d41);
    send_request(qnm_pkg::OP_MAT, 16'h0001, 16'hffff, 16'h0001, 16'hffff);
    send_request(qnm_pkg::OP_MAT, 16'h0000, 16'h4000, 16'h0000, 16'h0000);
    send_request(qnm_pkg::OP_MAT, 16'h2000, 16'he000, 16'h2000, 16'he000);
    send_request(qnm_pkg::OP_MAT, 16'h0040, 16'h0000, 16'h0000, 16'h0000);
    wait_drained();
  endtask

  task automatic random_quaternion(output logic [15:0] c[4]);
    int shape;
    shape = $urandom_range(0, 9);
    for (int i = 0; i < 4; i++) begin
      case (shape)
        0: begin
          c[i] = 16'($signed($urandom_range(0, 16)) - 8);
        end
        1, 2: begin
          c[i] = 16'($signed($urandom_range(0, 32768)) - 16384);
        end
        3: begin
          c[i] = ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7fff;
        end
        4: begin
          c[i] = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'h0000;
        end
        default: begin
          c[i] = 16'($urandom);
        end
      endcase
    end
  endtask

  task automatic test_random_stream(int count);
    logic [15:0]  c[4];
    qnm_pkg::op_t op;
    for (int n = 0; n < count; n++) begin
      random_quaternion(c);
      op = qnm_pkg::op_t'($urandom_range(0, 1));
      send_request(op, c[0], c[1], c[2], c[3]);
    end
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    logic [15:0] c[4];
    hold_cycles = 300;
    for (int n = 0; n < 80; n++) begin
      random_quaternion(c);
      send_request(qnm_pkg::op_t'($urandom_range(0, 1)), c[0], c[1], c[2], c[3], 1);
    end
    wait_drained();
  endtask

  task automatic test_back_to_back();
    logic [15:0] c[4];
    stall_mode = 0;
    for (int n = 0; n < 60; n++) begin
      random_quaternion(c);
      send_request(qnm_pkg::op_t'($urandom_range(0, 1)), c[0], c[1], c[2], c[3], 1);
    end
    wait_drained();
    stall_mode = 1;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_tready  <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 9) < 7);
        default: out_tready <= ($urandom_range(0, 9) < 3);
      endcase
      if (stall_mode != 0 && $urandom_range(0, 99) == 0) stall_mode <= $urandom_range(1, 2);
    end
  end

  always @(posedge clk) begin
    rotation_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %h", out_tdata);
      end else begin
        exp_r = pending_results.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (out_tdata[18*i +: 18] !== exp_r.entry[i]) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("r%0d: expected %h actual %h", i, exp_r.entry[i], out_tdata[18*i +: 18]);
          end
        end
        if (out_tdata[167:162] !== 6'h0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("pad: actual %h", out_tdata[167:162]);
        end
        if (out_tuser[0] !== exp_r.zero_norm) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("zero_norm: expected %b actual %b", exp_r.zero_norm, out_tuser[0]);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    out_tready     = 1'b0;
    mismatch_count = 0;
    burst_left     = 0;
    hold_cycles    = 0;
    stall_mode     = 1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_normalize_directed();
    test_matrix_directed();
    test_back_to_back();
    test_output_backpressure();
    test_random_stream(1040);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== quaternion_normalize_and_matrix_core.f =====
hw/rtl/qnm_pkg.sv
hw/rtl/qnm_norm_lane.sv
hw/rtl/quaternion_normalize_and_matrix_core.sv
verif/quaternion_normalize_and_matrix_core_tb.sv
